/* rtl/core/bft_pkg.sv */
`default_nettype none
package bft_pkg;

  localparam int FLOW_ENTRIES = 1024;
  localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);

  localparam int FLOW_INDEX_W = 10;
  localparam int ACTIVE_W = 11;
  localparam int PKT_W = 32;
  localparam int BYTE_W = 48;
  localparam int LEN_W = 16;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [31:0] HASH_SEED = 32'd17;
  localparam int HSTEP_W = 3;
  localparam logic [HSTEP_W-1:0] HF_SRC_ADDR = 3'd0;
  localparam logic [HSTEP_W-1:0] HF_DST_ADDR = 3'd1;
  localparam logic [HSTEP_W-1:0] HF_SRC_PORT = 3'd2;
  localparam logic [HSTEP_W-1:0] HF_DST_PORT = 3'd3;
  localparam logic [HSTEP_W-1:0] HF_PROTO = 3'd4;

  typedef enum logic [1:0] {
    ST_FWD_HIT  = 2'd0,
    ST_REV_HIT  = 2'd1,
    ST_INSERTED = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0]      source_address;
    logic [31:0]      dest_address;
    logic [15:0]      source_port;
    logic [15:0]      dest_port;
    logic [7:0]       protocol;
    logic [LEN_W-1:0] packet_length;
  } in_t;

  typedef struct packed {
    status_t                 status;
    logic [FLOW_INDEX_W-1:0] flow_index;
    logic [31:0]             flow_hash;
    logic [ACTIVE_W-1:0]     active_flows;
    logic [PKT_W-1:0]        fwd_packets;
    logic [BYTE_W-1:0]       fwd_bytes;
    logic [PKT_W-1:0]        rev_packets;
    logic [BYTE_W-1:0]       rev_bytes;
  } out_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] ports;
    logic [7:0]  proto;
  } key_t;

  typedef struct packed {
    logic [PKT_W-1:0]  fwd_pkts;
    logic [BYTE_W-1:0] fwd_bytes;
    logic [PKT_W-1:0]  rev_pkts;
    logic [BYTE_W-1:0] rev_bytes;
  } ctr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_INSERT,
    S_FULL,
    S_HASH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic update;
    logic insert;
    logic full;
    logic hash_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_done;
    logic table_full;
    logic hash_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/core/bft_ram.sv */
`default_nettype none
module bft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/core/bft_ctrl.sv */
`default_nettype none
module bft_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bft_pkg::sts_t sts,
  output bft_pkg::cmd_t      cmd
);

  bft_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bft_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      bft_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = bft_pkg::S_SCAN;
        end
      end
      bft_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit) begin
          state_nxt = bft_pkg::S_UPDATE;
        end else if (sts.scan_done) begin
          state_nxt = sts.table_full ? bft_pkg::S_FULL : bft_pkg::S_INSERT;
        end
      end
      bft_pkg::S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt = bft_pkg::S_HASH;
      end
      bft_pkg::S_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt = bft_pkg::S_HASH;
      end
      bft_pkg::S_FULL: begin
        cmd.full = 1'b1;
        state_nxt = bft_pkg::S_HASH;
      end
      bft_pkg::S_HASH: begin
        cmd.hash_step = 1'b1;
        if (sts.hash_done) begin
          state_nxt = bft_pkg::S_DONE;
        end
      end
      bft_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          state_nxt = bft_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bft_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/bft_dp.sv */
`default_nettype none
module bft_dp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire bft_pkg::in_t  in_data,
  input  wire bft_pkg::cmd_t cmd,
  output bft_pkg::sts_t      sts,
  output logic               out_valid,
  input  wire logic          out_ready,
  output bft_pkg::out_t      out_data
);

  localparam int IW = bft_pkg::IDX_W;
  localparam int CW = bft_pkg::CNT_W;

  // packet key, ports already cleared for non tcp/udp
  logic [31:0]              sa_r, da_r;
  logic [15:0]              sp_r, dp_r;
  logic [7:0]               pr_r;
  logic [bft_pkg::LEN_W-1:0] len_r;

  logic [CW-1:0]  entries_r;
  logic [CW-1:0]  ptr_r;
  logic [IW-1:0]  cmp_idx_r;
  logic           cmp_vld_r;
  logic [IW-1:0]  idx_r;
  logic           rev_r;
  bft_pkg::ctr_t  ctr_r;
  bft_pkg::ctr_t  res_ctr_r;
  bft_pkg::status_t res_status_r;
  logic [31:0]    hash_r;
  logic [bft_pkg::HSTEP_W-1:0] hstep_r;
  logic           out_valid_r;
  bft_pkg::out_t  out_r;

  logic           l4_ports;
  logic           issue;
  logic [IW-1:0]  raddr;
  logic [$bits(bft_pkg::key_t)-1:0] key_rd_bits;
  logic [$bits(bft_pkg::ctr_t)-1:0] ctr_rd_bits;
  bft_pkg::key_t  key_rd, key_wr;
  bft_pkg::ctr_t  ctr_rd, ctr_wr, ctr_upd, ctr_new;
  logic           fwd_m, rev_m;
  logic [IW-1:0]  ins_idx;
  logic           ctr_we;
  logic [IW-1:0]  ctr_waddr;
  logic [bft_pkg::PKT_W:0]  pkt_sum;
  logic [bft_pkg::BYTE_W:0] byte_sum;
  logic [bft_pkg::PKT_W-1:0]  pkt_sat;
  logic [bft_pkg::BYTE_W-1:0] byte_sat;
  logic [31:0]    hfield;
  logic [31:0]    hash_nxt;
  logic [IW+bft_pkg::FLOW_INDEX_W-1:0] idx_ext;
  logic [CW+bft_pkg::ACTIVE_W-1:0]     act_ext;

  assign l4_ports = (in_data.protocol == bft_pkg::PROTO_TCP) ||
                    (in_data.protocol == bft_pkg::PROTO_UDP);

  assign issue   = cmd.scan && (ptr_r != entries_r);
  assign raddr   = issue ? ptr_r[IW-1:0] : '0;
  assign ins_idx = entries_r[IW-1:0];

  assign key_rd = bft_pkg::key_t'(key_rd_bits);
  assign ctr_rd = bft_pkg::ctr_t'(ctr_rd_bits);

  always_comb begin
    key_wr.src_addr = sa_r;
    key_wr.dst_addr = da_r;
    key_wr.ports    = {sp_r, dp_r};
    key_wr.proto    = pr_r;
  end

  assign fwd_m = (key_rd.proto == pr_r) && (key_rd.src_addr == sa_r) &&
                 (key_rd.dst_addr == da_r) && (key_rd.ports == {sp_r, dp_r});
  assign rev_m = (key_rd.proto == pr_r) && (key_rd.src_addr == da_r) &&
                 (key_rd.dst_addr == sa_r) && (key_rd.ports == {dp_r, sp_r});

  // saturating update of the direction that matched
  always_comb begin
    pkt_sum  = rev_r ? {1'b0, ctr_r.rev_pkts} + (bft_pkg::PKT_W+1)'(1)
                     : {1'b0, ctr_r.fwd_pkts} + (bft_pkg::PKT_W+1)'(1);
    byte_sum = rev_r ? {1'b0, ctr_r.rev_bytes} + (bft_pkg::BYTE_W+1)'(len_r)
                     : {1'b0, ctr_r.fwd_bytes} + (bft_pkg::BYTE_W+1)'(len_r);
    pkt_sat  = pkt_sum[bft_pkg::PKT_W] ? '1 : pkt_sum[bft_pkg::PKT_W-1:0];
    byte_sat = byte_sum[bft_pkg::BYTE_W] ? '1 : byte_sum[bft_pkg::BYTE_W-1:0];
    ctr_upd = ctr_r;
    if (rev_r) begin
      ctr_upd.rev_pkts  = pkt_sat;
      ctr_upd.rev_bytes = byte_sat;
    end else begin
      ctr_upd.fwd_pkts  = pkt_sat;
      ctr_upd.fwd_bytes = byte_sat;
    end
  end

  always_comb begin
    ctr_new.fwd_pkts  = bft_pkg::PKT_W'(1);
    ctr_new.fwd_bytes = bft_pkg::BYTE_W'(len_r);
    ctr_new.rev_pkts  = '0;
    ctr_new.rev_bytes = '0;
  end

  assign ctr_we    = cmd.insert || cmd.update;
  assign ctr_waddr = cmd.insert ? ins_idx : idx_r;
  assign ctr_wr    = cmd.insert ? ctr_new : ctr_upd;

  // a reverse hit hashes the stored key, which is the packet key swapped
  always_comb begin
    case (hstep_r)
      bft_pkg::HF_SRC_ADDR: hfield = rev_r ? da_r : sa_r;
      bft_pkg::HF_DST_ADDR: hfield = rev_r ? sa_r : da_r;
      bft_pkg::HF_SRC_PORT: hfield = {16'd0, rev_r ? dp_r : sp_r};
      bft_pkg::HF_DST_PORT: hfield = {16'd0, rev_r ? sp_r : dp_r};
      bft_pkg::HF_PROTO:    hfield = {24'd0, pr_r};
      default:              hfield = '0;
    endcase
  end

  // h * 31 + field
  assign hash_nxt = (hash_r << 5) - hash_r + hfield;

  assign idx_ext = {{bft_pkg::FLOW_INDEX_W{1'b0}}, idx_r};
  assign act_ext = {{bft_pkg::ACTIVE_W{1'b0}}, entries_r};

  always_comb begin
    sts.hit        = cmd.scan && cmp_vld_r && (fwd_m || rev_m);
    sts.scan_done  = !cmp_vld_r && (ptr_r == entries_r);
    sts.table_full = (entries_r == CW'(bft_pkg::FLOW_ENTRIES));
    sts.hash_done  = (hstep_r == bft_pkg::HF_PROTO);
    sts.out_free   = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r   <= '0;
      ptr_r       <= '0;
      cmp_vld_r   <= 1'b0;
      hstep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        ptr_r     <= '0;
        cmp_vld_r <= 1'b0;
        hstep_r   <= '0;
      end else begin
        if (issue) begin
          ptr_r <= ptr_r + CW'(1);
        end
        cmp_vld_r <= issue;
        if (cmd.hash_step) begin
          hstep_r <= hstep_r + bft_pkg::HSTEP_W'(1);
        end
      end
      if (cmd.insert) begin
        entries_r <= entries_r + CW'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sa_r   <= in_data.source_address;
      da_r   <= in_data.dest_address;
      sp_r   <= l4_ports ? in_data.source_port : 16'd0;
      dp_r   <= l4_ports ? in_data.dest_port : 16'd0;
      pr_r   <= in_data.protocol;
      len_r  <= in_data.packet_length;
      rev_r  <= 1'b0;
      hash_r <= bft_pkg::HASH_SEED;
    end
    cmp_idx_r <= ptr_r[IW-1:0];
    if (sts.hit) begin
      idx_r <= cmp_idx_r;
      rev_r <= !fwd_m;
      ctr_r <= ctr_rd;
    end
    if (cmd.update) begin
      res_ctr_r    <= ctr_upd;
      res_status_r <= rev_r ? bft_pkg::ST_REV_HIT : bft_pkg::ST_FWD_HIT;
    end
    if (cmd.insert) begin
      idx_r        <= ins_idx;
      res_ctr_r    <= ctr_new;
      res_status_r <= bft_pkg::ST_INSERTED;
    end
    if (cmd.full) begin
      idx_r        <= '0;
      res_ctr_r    <= '0;
      res_status_r <= bft_pkg::ST_FULL;
    end
    if (cmd.hash_step) begin
      hash_r <= hash_nxt;
    end
    if (cmd.emit) begin
      out_r.status       <= res_status_r;
      out_r.flow_index   <= idx_ext[bft_pkg::FLOW_INDEX_W-1:0];
      out_r.flow_hash    <= hash_r;
      out_r.active_flows <= act_ext[bft_pkg::ACTIVE_W-1:0];
      out_r.fwd_packets  <= res_ctr_r.fwd_pkts;
      out_r.fwd_bytes    <= res_ctr_r.fwd_bytes;
      out_r.rev_packets  <= res_ctr_r.rev_pkts;
      out_r.rev_bytes    <= res_ctr_r.rev_bytes;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  bft_ram #(
    .WIDTH($bits(bft_pkg::key_t)),
    .DEPTH(bft_pkg::FLOW_ENTRIES)
  ) u_key_ram (
    .clk   (clk),
    .we    (cmd.insert),
    .waddr (ins_idx),
    .wdata (key_wr),
    .raddr (raddr),
    .rdata (key_rd_bits)
  );

  bft_ram #(
    .WIDTH($bits(bft_pkg::ctr_t)),
    .DEPTH(bft_pkg::FLOW_ENTRIES)
  ) u_ctr_ram (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (ctr_waddr),
    .wdata (ctr_wr),
    .raddr (raddr),
    .rdata (ctr_rd_bits)
  );

endmodule
`default_nettype wire

/* rtl/core/bidirectional_flow_table_top.sv */
`default_nettype none
// Bidirectional 5-tuple flow table. Each packet is looked up against the stored
// keys in insertion order, forward match before reverse match; a hit bumps that
// direction's saturating packet and byte counters, a miss inserts a new entry, and
// a miss with all entries in use reports table full. One result per transaction.
// The table holds up to 1024 entries, and a hit on an entry ends the search early.
// The search reads one stored key per cycle from a single key memory port, then
// waits for the memory read and the last compare. It is followed by the counter
// write or insert (or the table-full result), a hash step for each of the five
// key fields and the load of the output register. The next packet may be accepted
// while a result waits to be taken; it stalls before loading the output register
// until that result is taken. Stored entries need no clearing after reset; only
// entries below the fill count are searched.
module bidirectional_flow_table_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire bft_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output bft_pkg::out_t     out_data
);

  bft_pkg::cmd_t cmd;
  bft_pkg::sts_t sts;

  bft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bft_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* verif/flow_table_checker.sv */
module flow_table_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  bft_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  bft_pkg::out_t out_data,
  output int            fail_count,
  output int            pending
);
  import bft_pkg::*;

  key_t flow_key [FLOW_ENTRIES];
  ctr_t flow_ctr [FLOW_ENTRIES];
  int   flows_used;
  out_t awaiting_q [$];

  function automatic logic [31:0] tuple_hash(key_t k);
    logic [31:0] h;
    h = HASH_SEED;
    h = h * 32'd31 + k.src_addr;
    h = h * 32'd31 + k.dst_addr;
    h = h * 32'd31 + {16'd0, k.ports[31:16]};
    h = h * 32'd31 + {16'd0, k.ports[15:0]};
    h = h * 32'd31 + {24'd0, k.proto};
    return h;
  endfunction

  function automatic logic [PKT_W-1:0] bump_pkts(logic [PKT_W-1:0] c);
    return (c == '1) ? c : c + PKT_W'(1);
  endfunction

  function automatic logic [BYTE_W-1:0] add_bytes(logic [BYTE_W-1:0] c,
                                                  logic [LEN_W-1:0] len);
    logic [BYTE_W:0] sum;
    sum = {1'b0, c} + (BYTE_W+1)'(len);
    return sum[BYTE_W] ? '1 : sum[BYTE_W-1:0];
  endfunction

  // looks the packet up, updates the table copy and returns the expected result
  function automatic out_t track_packet(in_t pkt);
    key_t        fkey;
    logic [31:0] rports;
    status_t     st;
    int          hit_at;
    out_t        res;
    fkey.src_addr = pkt.source_address;
    fkey.dst_addr = pkt.dest_address;
    fkey.proto    = pkt.protocol;
    if (pkt.protocol == PROTO_TCP || pkt.protocol == PROTO_UDP) begin
      fkey.ports = {pkt.source_port, pkt.dest_port};
    end else begin
      fkey.ports = '0;
    end
    rports = {fkey.ports[15:0], fkey.ports[31:16]};
    st = ST_FULL;
    hit_at = 0;
    for (int i = 0; i < flows_used; i++) begin
      if (flow_key[i].proto == fkey.proto) begin
        if (flow_key[i].src_addr == fkey.src_addr && flow_key[i].dst_addr == fkey.dst_addr &&
            flow_key[i].ports == fkey.ports) begin
          st = ST_FWD_HIT;
          hit_at = i;
          break;
        end
        if (flow_key[i].src_addr == fkey.dst_addr && flow_key[i].dst_addr == fkey.src_addr &&
            flow_key[i].ports == rports) begin
          st = ST_REV_HIT;
          hit_at = i;
          break;
        end
      end
    end
    case (st)
      ST_FWD_HIT: begin
        flow_ctr[hit_at].fwd_pkts  = bump_pkts(flow_ctr[hit_at].fwd_pkts);
        flow_ctr[hit_at].fwd_bytes = add_bytes(flow_ctr[hit_at].fwd_bytes, pkt.packet_length);
      end
      ST_REV_HIT: begin
        flow_ctr[hit_at].rev_pkts  = bump_pkts(flow_ctr[hit_at].rev_pkts);
        flow_ctr[hit_at].rev_bytes = add_bytes(flow_ctr[hit_at].rev_bytes, pkt.packet_length);
      end
      default: begin
        if (flows_used < FLOW_ENTRIES) begin
          hit_at = flows_used;
          flow_key[hit_at] = fkey;
          flow_ctr[hit_at].fwd_pkts  = PKT_W'(1);
          flow_ctr[hit_at].fwd_bytes = BYTE_W'(pkt.packet_length);
          flow_ctr[hit_at].rev_pkts  = '0;
          flow_ctr[hit_at].rev_bytes = '0;
          flows_used++;
          st = ST_INSERTED;
        end
      end
    endcase
    res = '0;
    res.status = st;
    if (st == ST_FULL) begin
      res.flow_hash = tuple_hash(fkey);
    end else begin
      res.flow_index  = FLOW_INDEX_W'(hit_at);
      res.flow_hash   = tuple_hash(flow_key[hit_at]);
      res.fwd_packets = flow_ctr[hit_at].fwd_pkts;
      res.fwd_bytes   = flow_ctr[hit_at].fwd_bytes;
      res.rev_packets = flow_ctr[hit_at].rev_pkts;
      res.rev_bytes   = flow_ctr[hit_at].rev_bytes;
    end
    res.active_flows = ACTIVE_W'(flows_used);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t flow result %s mismatch: expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      flows_used = 0;
      awaiting_q.delete();
    end else begin
      // compare before queuing, so a stray result never meets a fresh prediction
      if (out_valid && out_ready) begin
        if (awaiting_q.size() == 0) begin
          $display("%0t unexpected flow result transaction: actual %0h", $time, out_data);
          fail_count++;
        end else begin
          want = awaiting_q.pop_front();
          check_field("status", 64'(want.status), 64'(out_data.status));
          check_field("flow_index", 64'(want.flow_index), 64'(out_data.flow_index));
          check_field("flow_hash", 64'(want.flow_hash), 64'(out_data.flow_hash));
          check_field("active_flows", 64'(want.active_flows), 64'(out_data.active_flows));
          check_field("fwd_packets", 64'(want.fwd_packets), 64'(out_data.fwd_packets));
          check_field("fwd_bytes", 64'(want.fwd_bytes), 64'(out_data.fwd_bytes));
          check_field("rev_packets", 64'(want.rev_packets), 64'(out_data.rev_packets));
          check_field("rev_bytes", 64'(want.rev_bytes), 64'(out_data.rev_bytes));
        end
      end
      if (in_valid && in_ready) begin
        awaiting_q.push_back(track_packet(in_data));
      end
    end
    pending = awaiting_q.size();
  end

endmodule

/* verif/tb_top.sv */
module tb_top;
  import bft_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic idling;
  int   fail_count;
  int   pending;

  // every key sent as a new flow, replayed later in either direction
  in_t flow_pool [$];

  bidirectional_flow_table_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  flow_table_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idling && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  function automatic in_t tuple_pkt(logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
                                    logic [15:0] dp, logic [7:0] pr, logic [15:0] len);
    in_t pkt;
    pkt.source_address = sa;
    pkt.dest_address   = da;
    pkt.source_port    = sp;
    pkt.dest_port      = dp;
    pkt.protocol       = pr;
    pkt.packet_length  = len;
    return pkt;
  endfunction

  function automatic logic [15:0] rand_length();
    case ($urandom_range(0, 9))
      0: return 16'hFFFF;
      1: return 16'h0000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic in_t fresh_packet();
    logic [7:0] pr;
    case ($urandom_range(0, 4))
      0, 1: pr = PROTO_TCP;
      2, 3: pr = PROTO_UDP;
      default: pr = 8'($urandom_range(0, 255));
    endcase
    return tuple_pkt($urandom, $urandom, 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), pr, rand_length());
  endfunction

  function automatic in_t replay_packet(int lo);
    in_t         pkt;
    logic [31:0] addr;
    logic [15:0] port;
    pkt = flow_pool[$urandom_range(lo, flow_pool.size() - 1)];
    // ports do not take part in the key outside tcp and udp
    if (pkt.protocol != PROTO_TCP && pkt.protocol != PROTO_UDP) begin
      pkt.source_port = 16'($urandom_range(0, 65535));
      pkt.dest_port   = 16'($urandom_range(0, 65535));
    end
    if ($urandom_range(0, 1) == 1) begin
      addr = pkt.source_address;
      pkt.source_address = pkt.dest_address;
      pkt.dest_address = addr;
      port = pkt.source_port;
      pkt.source_port = pkt.dest_port;
      pkt.dest_port = port;
    end
    pkt.packet_length = rand_length();
    return pkt;
  endfunction

  task automatic send_pkt(input in_t pkt);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pkt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_new(input in_t pkt);
    flow_pool.push_back(pkt);
    send_pkt(pkt);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    @(negedge clk);
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    idling   = 1'b1;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // all-zero key, then the same key with ports that do not count
    send_new(tuple_pkt('0, '0, '0, '0, 8'd0, '0));
    send_pkt(tuple_pkt('0, '0, 16'hFFFF, 16'hFFFF, 8'd0, 16'hFFFF));
    // all-ones key is its own reversal, so the repeat must hit forward
    send_new(tuple_pkt('1, '1, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF));
    send_pkt(tuple_pkt('1, '1, 16'hFFFF, 16'hFFFF, 8'hFF, 16'd1));
    send_new(tuple_pkt(32'h0A00_0001, 32'hC0A8_0001, 16'd1234, 16'd80, PROTO_TCP, 16'd60));
    send_pkt(tuple_pkt(32'hC0A8_0001, 32'h0A00_0001, 16'd80, 16'd1234, PROTO_TCP, 16'd1500));
    send_pkt(tuple_pkt(32'h0A00_0001, 32'hC0A8_0001, 16'd1234, 16'd80, PROTO_TCP, 16'd40));
    send_new(tuple_pkt(32'hFFFF_FFFE, 32'h0000_0001, 16'hFFFF, 16'h0000, PROTO_UDP, 16'h8000));
    send_pkt(tuple_pkt(32'h0000_0001, 32'hFFFF_FFFE, 16'h0000, 16'hFFFF, PROTO_UDP, 16'hFFFF));
    send_new(tuple_pkt(32'h8000_0000, 32'h0000_0080, 16'd5, 16'd7, 8'd1, 16'd84));
    send_pkt(tuple_pkt(32'h8000_0000, 32'h0000_0080, 16'hAAAA, 16'h5555, 8'd1, 16'd84));
    send_pkt(tuple_pkt(32'h0000_0080, 32'h8000_0000, 16'd9, 16'd9, 8'd1, 16'd84));
    send_new(tuple_pkt(32'h1234_5678, 32'h1234_5678, 16'd443, 16'd443, PROTO_TCP, 16'd100));
    send_pkt(tuple_pkt(32'h1234_5678, 32'h1234_5678, 16'd443, 16'd443, PROTO_TCP, 16'd0));
    // same addresses and ports as earlier flows under another protocol
    send_new(tuple_pkt(32'h0A00_0001, 32'hC0A8_0001, 16'd1234, 16'd80, PROTO_UDP, 16'd64));
    send_new(tuple_pkt(32'hFFFF_FFFE, 32'h0000_0001, 16'hFFFF, 16'h0000, PROTO_TCP, 16'd1));

    for (int n = 0; n < 500; n++) begin
      if (n == 250) drain();
      if ($urandom_range(0, 3) == 0) send_new(fresh_packet());
      else send_pkt(replay_packet(0));
    end

    // closing stretch with no idling, replays leaning on recent flows
    drain();
    idling = 1'b0;
    for (int n = 0; n < 60; n++) begin
      if ($urandom_range(0, 2) == 0) send_new(fresh_packet());
      else if ($urandom_range(0, 1) == 0)
        send_pkt(replay_packet((flow_pool.size() > 48) ? flow_pool.size() - 48 : 0));
      else send_pkt(replay_packet(0));
    end

    drain();
    repeat (1100) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
